/* design/latlng_to_unit_vector_assert.svh */
// Assertion macros for the latitude/longitude to unit vector block.
`ifndef LATLNG_TO_UNIT_VECTOR_ASSERT_SVH
`define LATLNG_TO_UNIT_VECTOR_ASSERT_SVH

`ifndef SYNTH

`define LTUV_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ltuv assertion failed");

`define LTUV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ltuv assertion failed");

`else

`define LTUV_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)

`define LTUV_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* design/ltuv_pkg.sv */
// Types, constants and helper functions shared by the unit vector pipeline.
package ltuv_pkg;

  localparam int CORDIC_STAGES_DEF = 30;
  localparam int DP_W = 36;

  typedef logic signed [30:0]     lat_t;
  typedef logic signed [31:0]     lng_t;
  typedef logic signed [31:0]     comp_t;
  typedef logic signed [DP_W-1:0] dp_t;
  typedef logic signed [63:0]     prod_t;

  localparam lat_t HALF_PI_LAT = 31'sd843314857;
  localparam lng_t HALF_PI_LNG = 32'sd843314857;
  localparam lng_t PI_Q29      = 32'sd1686629713;
  localparam dp_t  GAIN_Q32    = 36'sd2608131496;

  localparam dp_t ATAN_SMALL [11] = '{
    36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
    36'sd268086748,  36'sd134174063,  36'sd67103403,   36'sd33553749,
    36'sd16777131,   36'sd8388597,    36'sd4194303
  };

  typedef struct packed {
    dp_t x;
    dp_t y;
    dp_t z;
  } cordic_lane_t;

  typedef struct packed {
    logic         valid;
    logic         flip;
    cordic_lane_t lat;
    cordic_lane_t lng;
  } cordic_stage_t;

  function automatic dp_t atan_entry(int unsigned i);
    dp_t r;
    if (i < 11) begin
      r = ATAN_SMALL[i];
    end else if (i <= 32) begin
      r = dp_t'(36'sd1 <<< (32 - i));
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic cordic_lane_t cordic_rot(cordic_lane_t a, int unsigned i);
    cordic_lane_t r;
    dp_t dx;
    dp_t dy;
    dp_t at;
    dx = a.y >>> i;
    dy = a.x >>> i;
    at = atan_entry(i);
    if (!a.z[DP_W-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - at;
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + at;
    end
    return r;
  endfunction

  function automatic comp_t round_q30(dp_t v);
    dp_t t;
    comp_t r;
    t = (v + 36'sd2) >>> 2;
    if (t > 36'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (t < -36'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

  function automatic comp_t round_prod(prod_t p);
    prod_t t;
    comp_t r;
    t = (p + 64'sd536870912) >>> 30;
    if (t > 64'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (t < -64'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

endpackage

/* design/ltuv_if.sv */
// Valid/ready channel interfaces for angle input and unit vector output.
interface ltuv_in_if;
  import ltuv_pkg::*;
  logic valid;
  logic ready;
  lat_t latitude;
  lng_t longitude;
  modport source (output valid, output latitude, output longitude, input ready);
  modport sink (input valid, input latitude, input longitude, output ready);
endinterface

interface ltuv_out_if;
  import ltuv_pkg::*;
  logic  valid;
  logic  ready;
  comp_t unit_x;
  comp_t unit_y;
  comp_t unit_z;
  modport source (output valid, output unit_x, output unit_y, output unit_z, input ready);
  modport sink (input valid, input unit_x, input unit_y, input unit_z, output ready);
endinterface

/* design/ltuv_cordic.sv */
// Pipelined dual-lane CORDIC rotator, one register stage per iteration.
module ltuv_cordic #(
  parameter int CORDIC_STAGES = ltuv_pkg::CORDIC_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  ltuv_pkg::cordic_stage_t stage_in,
  output ltuv_pkg::cordic_stage_t stage_out
);
  import ltuv_pkg::*;

  cordic_stage_t stage_pipe [CORDIC_STAGES+1];

  assign stage_pipe[0] = stage_in;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    cordic_stage_t stage_nxt;
    cordic_stage_t stage_r;

    always_comb begin
      stage_nxt.valid = stage_pipe[i].valid;
      stage_nxt.flip  = stage_pipe[i].flip;
      stage_nxt.lat   = cordic_rot(stage_pipe[i].lat, i);
      stage_nxt.lng   = cordic_rot(stage_pipe[i].lng, i);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r.valid <= 1'b0;
      end else if (en) begin
        stage_r.valid <= stage_nxt.valid;
      end
      if (en) begin
        stage_r.flip <= stage_nxt.flip;
        stage_r.lat  <= stage_nxt.lat;
        stage_r.lng  <= stage_nxt.lng;
      end
    end

    assign stage_pipe[i+1] = stage_r;
  end

  assign stage_out = stage_pipe[CORDIC_STAGES];

endmodule

/* design/latlng_to_unit_vector.sv */
// Top level: latitude/longitude in radians to a point on the unit sphere.
//
// in_chan carries one transaction per point: latitude (Q1.29, 31 bits) and
// longitude (Q2.29, 32 bits), both in radians; out-of-range angles saturate.
// out_chan returns one transaction per point: unit_x, unit_y, unit_z (Q1.30).
// The pipeline is CORDIC_STAGES + 4 register stages deep: one for saturation
// and quadrant folding, one per CORDIC iteration, one for rounding, one for
// the two 32x32 multipliers and one output register; the CORDIC iterations
// set that depth. A new point is taken every cycle while the pipeline is not
// stalled.
// When out_chan.ready is low and the output register holds a result, the
// whole pipeline holds, and in_chan.ready drops in the same cycle; nothing
// is lost or repeated. Reset clears all valid bits; the block keeps no other
// state, so results depend only on their own transaction.
module latlng_to_unit_vector #(
  parameter int CORDIC_STAGES = ltuv_pkg::CORDIC_STAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ltuv_in_if.sink    in_chan,
  ltuv_out_if.source out_chan
);
  import ltuv_pkg::*;

  logic adv;
  assign adv = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = adv;

  lat_t          lat_sat;
  lng_t          lng_sat;
  lng_t          lng_fold;
  logic          flip;
  cordic_stage_t s0_nxt;
  cordic_stage_t s0_r;

  always_comb begin
    if (in_chan.latitude > HALF_PI_LAT) begin
      lat_sat = HALF_PI_LAT;
    end else if (in_chan.latitude < -HALF_PI_LAT) begin
      lat_sat = -HALF_PI_LAT;
    end else begin
      lat_sat = in_chan.latitude;
    end
    if (in_chan.longitude > PI_Q29) begin
      lng_sat = PI_Q29;
    end else if (in_chan.longitude < -PI_Q29) begin
      lng_sat = -PI_Q29;
    end else begin
      lng_sat = in_chan.longitude;
    end
    if (lng_sat > HALF_PI_LNG) begin
      lng_fold = lng_sat - PI_Q29;
      flip     = 1'b1;
    end else if (lng_sat < -HALF_PI_LNG) begin
      lng_fold = lng_sat + PI_Q29;
      flip     = 1'b1;
    end else begin
      lng_fold = lng_sat;
      flip     = 1'b0;
    end
    s0_nxt.valid = in_chan.valid;
    s0_nxt.flip  = flip;
    s0_nxt.lat.x = GAIN_Q32;
    s0_nxt.lat.y = '0;
    s0_nxt.lat.z = dp_t'({{(DP_W-31){lat_sat[30]}}, lat_sat}) <<< 3;
    s0_nxt.lng.x = GAIN_Q32;
    s0_nxt.lng.y = '0;
    s0_nxt.lng.z = dp_t'({{(DP_W-32){lng_fold[31]}}, lng_fold}) <<< 3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else if (adv) begin
      s0_r.valid <= s0_nxt.valid;
    end
    if (adv) begin
      s0_r.flip <= s0_nxt.flip;
      s0_r.lat  <= s0_nxt.lat;
      s0_r.lng  <= s0_nxt.lng;
    end
  end

  cordic_stage_t cor_out;

  ltuv_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .stage_in (s0_r),
    .stage_out(cor_out)
  );

  // round to Q1.30 and undo the longitude fold
  logic  s1_valid_r;
  comp_t clat_r;
  comp_t slat_r;
  comp_t clng_r;
  comp_t slng_r;
  comp_t clng_nxt;
  comp_t slng_nxt;

  always_comb begin
    clng_nxt = round_q30(cor_out.lng.x);
    slng_nxt = round_q30(cor_out.lng.y);
    if (cor_out.flip) begin
      clng_nxt = -clng_nxt;
      slng_nxt = -slng_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= cor_out.valid;
    end
    if (adv) begin
      clat_r <= round_q30(cor_out.lat.x);
      slat_r <= round_q30(cor_out.lat.y);
      clng_r <= clng_nxt;
      slng_r <= slng_nxt;
    end
  end

  logic  s2_valid_r;
  prod_t px_r;
  prod_t py_r;
  comp_t z2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
    if (adv) begin
      px_r <= prod_t'(clng_r) * prod_t'(clat_r);
      py_r <= prod_t'(slng_r) * prod_t'(clat_r);
      z2_r <= slat_r;
    end
  end

  logic  out_valid_r;
  comp_t unit_x_r;
  comp_t unit_y_r;
  comp_t unit_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
    if (adv) begin
      unit_x_r <= round_prod(px_r);
      unit_y_r <= round_prod(py_r);
      unit_z_r <= z2_r;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.unit_x = unit_x_r;
  assign out_chan.unit_y = unit_y_r;
  assign out_chan.unit_z = unit_z_r;

  `include "latlng_to_unit_vector_assert.svh"

  `LTUV_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_chan.valid && in_chan.ready, s0_r.valid)
  `LTUV_ASSERT_NEXT(a_stall_holds_pipe, clk, rst_n, !adv,
                    $stable(s1_valid_r) && $stable(s2_valid_r) && $stable(px_r))
  `LTUV_ASSERT_IMPLY(a_z_in_range, clk, rst_n, out_valid_r,
                     unit_z_r <= 32'sd1073741824 && unit_z_r >= -32'sd1073741824)

endmodule
